FILE: hw/rtl/smp_pkg.sv
`default_nettype none

package smp_pkg;

    localparam int MAX_BPS_DEF = 4;   // default for MAX_BITS_PER_SYMBOL
    localparam int ENTRY_W     = 4;   // one mapping entry
    localparam int BIT_IDX_W   = $clog2(ENTRY_W);
    localparam int SYM_W       = 4;   // symbol index as carried in the queue
    localparam int BPS_W       = 3;
    localparam int REQ_W       = 2;
    localparam int CHAR_W      = 8;
    localparam int WORD_W      = 64;
    localparam int PERM_W      = 48;
    localparam int QUEUE_DEPTH = 2;   // power of two

    localparam logic [BPS_W-1:0]  BPS_RESET = 3'd2;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;

    localparam logic [REQ_W-1:0] REQ_RESTART = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ADVANCE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_MAP     = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NONE    = 2'd3;

    typedef enum logic [1:0] {
        OP_RESTART,
        OP_ADVANCE,
        OP_MAP
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [SYM_W-1:0] sym;
    } t_cmd;

endpackage

`default_nettype wire

FILE: hw/rtl/symbol_mapping_permuter.sv
// A restart word gives its result from the report state; a map word gives its bits
//   one per cycle while the output is not stalled (bps results).
// An advance goes through swap, n - 1 odd-even sort rounds (n = 2^bps) and report.
//   An advance with no successor reports like a restart.
// The back end takes a new request only once idle again; a 2-word queue in front.
// Reset (synchronous, active low) loads the identity mapping, index 0, bps = 2.
`default_nettype none

module symbol_mapping_permuter import smp_pkg::*; #(
    parameter int MAX_BITS_PER_SYMBOL = MAX_BPS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [REQ_W-1:0]  i_req_type,
    input  wire logic [CHAR_W-1:0] i_symbol_char,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic                   o_bit_value,
    output logic                   o_last,
    output logic [WORD_W-1:0]      o_mapping_word,
    output logic                   o_gray_flag,
    output logic [PERM_W-1:0]      o_perm_number,
    output logic                   o_exhausted,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [BPS_W-1:0]  i_cfg_data
);

    logic             w_push;
    logic             w_pop;
    logic             w_full;
    logic             w_empty;
    t_cmd             w_cmd_in;
    t_cmd             w_cmd_out;
    logic [BPS_W-1:0] w_bps;

    smp_front #(
        .MAX_BITS_PER_SYMBOL(MAX_BITS_PER_SYMBOL)
    ) u_front (
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_symbol_char (i_symbol_char),
        .i_bps         (w_bps),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_cmd         (w_cmd_in)
    );

    smp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cmd_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_cmd_out),
        .o_empty (w_empty)
    );

    smp_back #(
        .MAX_BITS_PER_SYMBOL(MAX_BITS_PER_SYMBOL)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (w_cmd_out),
        .i_empty        (w_empty),
        .o_pop          (w_pop),
        .o_bps          (w_bps),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_bit_value    (o_bit_value),
        .o_last         (o_last),
        .o_mapping_word (o_mapping_word),
        .o_gray_flag    (o_gray_flag),
        .o_perm_number  (o_perm_number),
        .o_exhausted    (o_exhausted)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/smp_front.sv
`default_nettype none

module smp_front import smp_pkg::*; #(
    parameter int MAX_BITS_PER_SYMBOL = MAX_BPS_DEF
) (
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [REQ_W-1:0]  i_req_type,
    input  wire logic [CHAR_W-1:0] i_symbol_char,
    input  wire logic [BPS_W-1:0]  i_bps,
    input  wire logic              i_full,
    output logic                   o_push,
    output t_cmd                   o_cmd
);

    localparam int IDX_W = MAX_BITS_PER_SYMBOL;

    logic [CHAR_W-1:0] w_diff;
    logic [IDX_W-1:0]  w_mask;
    logic [IDX_W-1:0]  w_sym;
    logic              w_keep;

    assign o_in_stall = i_full;

    // symbol offset wraps mod 256, then keeps only bps bits
    assign w_diff = i_symbol_char - CHAR_ZERO;
    assign w_mask = IDX_W'(((IDX_W+1)'(1) << i_bps) - (IDX_W+1)'(1));
    assign w_sym  = w_diff[IDX_W-1:0] & w_mask;

    always_comb begin
        o_cmd.op  = OP_RESTART;
        o_cmd.sym = SYM_W'(w_sym);
        w_keep    = 1'b1;
        unique case (i_req_type)
            REQ_RESTART: o_cmd.op = OP_RESTART;
            REQ_ADVANCE: o_cmd.op = OP_ADVANCE;
            REQ_MAP:     o_cmd.op = OP_MAP;
            REQ_NONE:    w_keep   = 1'b0;   // accepted and dropped
        endcase
    end

    assign o_push = i_in_valid && !i_full && w_keep;

endmodule

`default_nettype wire

FILE: hw/rtl/smp_fifo.sv
`default_nettype none

module smp_fifo import smp_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_cmd      i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output t_cmd      o_data,
    output logic      o_empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W:0]   r_count;

    assign o_full  = (r_count == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wr] <= i_data;
                r_wr        <= r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (PTR_W+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (PTR_W+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/smp_back.sv
`default_nettype none

module smp_back import smp_pkg::*; #(
    parameter int MAX_BITS_PER_SYMBOL = MAX_BPS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [BPS_W-1:0]  i_cfg_data,
    input  t_cmd                   i_cmd,
    input  wire logic              i_empty,
    output logic                   o_pop,
    output logic [BPS_W-1:0]       o_bps,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic                   o_bit_value,
    output logic                   o_last,
    output logic [WORD_W-1:0]      o_mapping_word,
    output logic                   o_gray_flag,
    output logic [PERM_W-1:0]      o_perm_number,
    output logic                   o_exhausted
);

    localparam int IDX_W = MAX_BITS_PER_SYMBOL;
    localparam int DEPTH = 1 << IDX_W;
    localparam logic [BPS_W-1:0] BPS_INIT =
        (BPS_RESET > BPS_W'(MAX_BITS_PER_SYMBOL)) ? BPS_W'(MAX_BITS_PER_SYMBOL) : BPS_RESET;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWAP,
        ST_SORT,
        ST_MAP,
        ST_REPORT
    } t_state;

    t_state               r_state;
    logic [ENTRY_W-1:0]   r_tab [DEPTH];
    logic [BPS_W-1:0]     r_bps;
    logic [PERM_W-1:0]    r_perm;
    logic                 r_done;
    logic [IDX_W-1:0]     r_piv_idx;
    logic [ENTRY_W-1:0]   r_piv_val;
    logic [IDX_W-1:0]     r_round;
    logic [ENTRY_W-1:0]   r_val;
    logic [BIT_IDX_W-1:0] r_bit_cnt;
    logic                 r_out_valid;
    logic                 r_bit_value;
    logic                 r_last;
    logic [WORD_W-1:0]    r_word;
    logic                 r_gray;
    logic [PERM_W-1:0]    r_perm_out;
    logic                 r_exh;

    logic [ENTRY_W-1:0]   n_tab_sorted [DEPTH];
    logic [IDX_W:0]       w_n;
    logic [DEPTH-1:0]     w_active;
    logic                 w_i_found;
    logic [IDX_W-1:0]     w_i_idx;
    logic [IDX_W-1:0]     w_j_idx;
    logic [ENTRY_W-1:0]   w_j_val;
    logic                 w_last_round;
    logic [WORD_W-1:0]    w_word;
    logic                 w_gray;
    logic                 w_out_free;
    logic                 w_cfg_we;
    logic [BPS_W-1:0]     w_cfg_bps;

    assign o_bps       = r_bps;
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;
    assign o_pop       = (r_state == ST_IDLE) && !i_empty && !w_cfg_we;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        if (i_cfg_data == '0) begin
            w_cfg_bps = BPS_W'(1);
        end else if (i_cfg_data > BPS_W'(MAX_BITS_PER_SYMBOL)) begin
            w_cfg_bps = BPS_W'(MAX_BITS_PER_SYMBOL);
        end else begin
            w_cfg_bps = i_cfg_data;
        end
    end

    assign w_n = (IDX_W+1)'(1) << r_bps;

    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            w_active[k] = ((IDX_W+1)'(k) < w_n);
        end
    end

    // pivot: rightmost ascent inside the active entries
    always_comb begin
        w_i_found = 1'b0;
        w_i_idx   = '0;
        for (int k = 0; k < DEPTH - 1; k++) begin
            if (w_active[k+1] && (r_tab[k] < r_tab[k+1])) begin
                w_i_found = 1'b1;
                w_i_idx   = IDX_W'(k);
            end
        end
    end

    // rightmost entry past the pivot that is larger than it
    always_comb begin
        w_j_idx = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (w_active[k] && (IDX_W'(k) > r_piv_idx) && (r_tab[k] > r_piv_val)) begin
                w_j_idx = IDX_W'(k);
            end
        end
    end

    assign w_j_val = r_tab[w_j_idx];

    // one odd-even transposition round over the suffix after the pivot
    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            n_tab_sorted[k] = r_tab[k];
        end
        for (int k = 0; k < DEPTH - 1; k++) begin
            if ((1'(k) == r_round[0]) && (IDX_W'(k) > r_piv_idx) && w_active[k+1]
                && (r_tab[k] > r_tab[k+1])) begin
                n_tab_sorted[k]   = r_tab[k+1];
                n_tab_sorted[k+1] = r_tab[k];
            end
        end
    end

    assign w_last_round = (r_round == IDX_W'(w_n - (IDX_W+1)'(2)));

    always_comb begin
        logic [ENTRY_W-1:0] x;
        w_word = '0;
        w_gray = 1'b1;
        x      = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (w_active[k]) begin
                w_word[ENTRY_W*k +: ENTRY_W] = r_tab[k];
            end
        end
        for (int k = 1; k < DEPTH; k++) begin
            x = r_tab[k] ^ r_tab[k-1];
            if (w_active[k] && ((x == '0) || ((x & (x - ENTRY_W'(1))) != '0))) begin
                w_gray = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_bps       <= BPS_INIT;
            r_perm      <= '0;
            r_done      <= 1'b0;
            for (int k = 0; k < DEPTH; k++) begin
                r_tab[k] <= ENTRY_W'(k);
            end
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (w_cfg_we) begin
                r_bps  <= w_cfg_bps;
                r_perm <= '0;
                r_done <= 1'b0;
                for (int k = 0; k < DEPTH; k++) begin
                    r_tab[k] <= ENTRY_W'(k);
                end
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        unique case (i_cmd.op)
                            OP_RESTART: begin
                                r_perm  <= '0;
                                r_done  <= 1'b0;
                                for (int k = 0; k < DEPTH; k++) begin
                                    r_tab[k] <= ENTRY_W'(k);
                                end
                                r_state <= ST_REPORT;
                            end
                            OP_ADVANCE: begin
                                if (r_done) begin
                                    r_state <= ST_REPORT;
                                end else if (!w_i_found) begin
                                    r_done  <= 1'b1;
                                    r_state <= ST_REPORT;
                                end else begin
                                    r_piv_idx <= w_i_idx;
                                    r_piv_val <= r_tab[w_i_idx];
                                    r_state   <= ST_SWAP;
                                end
                            end
                            OP_MAP: begin
                                r_val     <= r_tab[i_cmd.sym[IDX_W-1:0]];
                                r_bit_cnt <= BIT_IDX_W'(r_bps - BPS_W'(1));
                                r_state   <= ST_MAP;
                            end
                            default: r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_SWAP: begin
                    r_tab[r_piv_idx] <= w_j_val;
                    r_tab[w_j_idx]   <= r_piv_val;
                    r_perm           <= r_perm + PERM_W'(1);
                    r_round          <= '0;
                    r_state          <= ST_SORT;
                end
                ST_SORT: begin
                    r_tab   <= n_tab_sorted;
                    r_round <= r_round + IDX_W'(1);
                    if (w_last_round) begin
                        r_state <= ST_REPORT;
                    end
                end
                ST_MAP: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_bit_value <= r_val[r_bit_cnt];
                        r_last      <= (r_bit_cnt == '0);
                        r_word      <= w_word;
                        r_gray      <= w_gray;
                        r_perm_out  <= r_perm;
                        r_exh       <= r_done;
                        if (r_bit_cnt == '0) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_bit_cnt <= r_bit_cnt - BIT_IDX_W'(1);
                        end
                    end
                end
                ST_REPORT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_bit_value <= 1'b0;
                        r_last      <= 1'b1;
                        r_word      <= w_word;
                        r_gray      <= w_gray;
                        r_perm_out  <= r_perm;
                        r_exh       <= r_done;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_bit_value    = r_bit_value;
    assign o_last         = r_last;
    assign o_mapping_word = r_word;
    assign o_gray_flag    = r_gray;
    assign o_perm_number  = r_perm_out;
    assign o_exhausted    = r_exh;

endmodule

`default_nettype wire

FILE: hw/rtl/smp_checker.sv
`default_nettype none

module smp_checker import smp_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input wire logic              o_bit_value,
    input wire logic              o_last,
    input wire logic [WORD_W-1:0] o_mapping_word,
    input wire logic [PERM_W-1:0] o_perm_number,
    input wire logic              o_exhausted
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_mapping_word)
            && $stable(o_perm_number) && $stable(o_bit_value) && $stable(o_last))
        else $error("result word changed under stall");

    // a set mapped bit comes from a nonzero active entry
    a_bit_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bit_value |-> o_mapping_word != '0)
        else $error("mapped bit set with empty mapping");

    // index zero is always the identity
    a_first_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_perm_number == '0) |-> o_mapping_word[7:0] == 8'h10)
        else $error("index zero without identity mapping");

    // exhaustion needs at least one advance
    a_exh_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_exhausted |-> o_perm_number != '0)
        else $error("exhausted at index zero");

endmodule

bind symbol_mapping_permuter smp_checker u_smp_checker (.*);

`default_nettype wire

FILE: tb/tb_symbol_mapping_permuter.sv
`timescale 1ns / 1ps

module tb_symbol_mapping_permuter;
    import smp_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE_CYCLES = 60;
    localparam int HOLD_CYCLES = 150;

    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [CHAR_W-1:0] ch;
    } t_req_word;

    typedef struct {
        logic              bitv;
        logic              lastv;
        logic [WORD_W-1:0] word;
        logic              gray;
        logic [PERM_W-1:0] perm;
        logic              exh;
    } t_map_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [REQ_W-1:0]  i_req_type = REQ_RESTART;
    logic [CHAR_W-1:0] i_symbol_char = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic              o_bit_value;
    logic              o_last;
    logic [WORD_W-1:0] o_mapping_word;
    logic              o_gray_flag;
    logic [PERM_W-1:0] o_perm_number;
    logic              o_exhausted;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [BPS_W-1:0]  i_cfg_data = '0;

    symbol_mapping_permuter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_symbol_char  (i_symbol_char),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_bit_value    (o_bit_value),
        .o_last         (o_last),
        .o_mapping_word (o_mapping_word),
        .o_gray_flag    (o_gray_flag),
        .o_perm_number  (o_perm_number),
        .o_exhausted    (o_exhausted),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // mirror of the block state
    logic [ENTRY_W-1:0] perm_tbl [16];
    logic [PERM_W-1:0]  perm_cnt;
    logic               perm_done;
    logic [BPS_W-1:0]   bps_reg;

    t_req_word   req_fifo [$];
    t_map_result want_q [$];

    int   err_cnt = 0;
    int   cyc_cnt = 0;
    logic in_fire = 1'b0;
    logic cfg_taken = 1'b0;
    bit   tx_calm = 1'b0;
    bit   rx_calm = 1'b0;
    bit   rx_hold_req = 1'b0;
    bit   rx_hold_seen = 1'b0;
    int   tx_gap = 0;
    int   rx_run = 0;
    int   hold_left = 0;

    function automatic int eff_bps();
        int b;
        b = int'(bps_reg);
        if (b < 1) b = 1;
        if (b > MAX_BPS_DEF) b = MAX_BPS_DEF;
        return b;
    endfunction

    function automatic void load_identity();
        for (int k = 0; k < 16; k++) perm_tbl[k] = ENTRY_W'(k);
        perm_cnt = '0;
        perm_done = 1'b0;
    endfunction

    function automatic logic [WORD_W-1:0] packed_map();
        logic [WORD_W-1:0] w;
        int n;
        w = '0;
        n = 1 << eff_bps();
        for (int k = 0; k < n; k++) w[4*k +: 4] = perm_tbl[k];
        return w;
    endfunction

    function automatic logic gray_now();
        int n;
        n = 1 << eff_bps();
        for (int k = 1; k < n; k++)
            if ($countones(perm_tbl[k] ^ perm_tbl[k-1]) != 1) return 1'b0;
        return 1'b1;
    endfunction

    // lexicographic successor in place; 0 when the last permutation is reached
    function automatic bit step_perm();
        int n, i, j, lo, hi;
        logic [ENTRY_W-1:0] t;
        n = 1 << eff_bps();
        i = n - 2;
        while (i >= 0 && perm_tbl[i] >= perm_tbl[i+1]) i--;
        if (i < 0) return 1'b0;
        j = n - 1;
        while (perm_tbl[j] <= perm_tbl[i]) j--;
        t = perm_tbl[i];
        perm_tbl[i] = perm_tbl[j];
        perm_tbl[j] = t;
        lo = i + 1;
        hi = n - 1;
        while (lo < hi) begin
            t = perm_tbl[lo];
            perm_tbl[lo] = perm_tbl[hi];
            perm_tbl[hi] = t;
            lo++;
            hi--;
        end
        return 1'b1;
    endfunction

    function automatic void push_result(logic bitv, logic lastv, logic exh);
        want_q.push_back('{bitv, lastv, packed_map(), gray_now(), perm_cnt, exh});
    endfunction

    function automatic void apply_request(t_req_word w);
        int bps;
        logic [CHAR_W-1:0] d;
        logic [3:0] sym, val;
        case (w.req)
            REQ_RESTART: begin
                load_identity();
                push_result(1'b0, 1'b1, 1'b0);
            end
            REQ_ADVANCE: begin
                if (!perm_done) begin
                    if (step_perm()) perm_cnt = perm_cnt + PERM_W'(1);
                    else perm_done = 1'b1;
                end
                push_result(1'b0, 1'b1, perm_done);
            end
            REQ_MAP: begin
                bps = eff_bps();
                d = w.ch - CHAR_ZERO;
                sym = d[3:0] & 4'((1 << bps) - 1);
                val = perm_tbl[sym];
                for (int k = 0; k < bps; k++)
                    push_result(val[bps-1-k], k == bps - 1, perm_done);
            end
            default: ;
        endcase
    endfunction

    task automatic flag_mismatch(string what, logic [WORD_W-1:0] got,
                                 logic [WORD_W-1:0] exp_v);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, exp_v);
        err_cnt++;
    endtask

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 6);
        return $urandom_range(10, 40);
    endfunction

    // input side
    always @(negedge i_clk) begin
        t_req_word w;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_fire) begin
            // word still waiting, hold it
        end else if (tx_gap > 0) begin
            tx_gap--;
            i_in_valid <= 1'b0;
        end else if (req_fifo.size() > 0) begin
            w = req_fifo.pop_front();
            i_in_valid <= 1'b1;
            i_req_type <= w.req;
            i_symbol_char <= w.ch;
            tx_gap = (tx_calm || $urandom_range(0, 1)) ? 0 : idle_len();
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // output side stall
    always @(negedge i_clk) begin
        if (rx_hold_req && !rx_hold_seen) begin
            rx_hold_seen = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (rx_run > 0) begin
            rx_run--;
        end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
            i_out_stall <= 1'b1;
            rx_run = idle_len();
        end else begin
            i_out_stall <= 1'b0;
            rx_run = $urandom_range(0, 6);
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        t_map_result exp_r;
        in_fire <= i_in_valid && !o_in_stall;
        cfg_taken <= i_cfg_valid && o_cfg_ready;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                apply_request('{i_req_type, i_symbol_char});
            if (i_cfg_valid && o_cfg_ready) begin
                bps_reg = i_cfg_data;
                load_identity();
            end
            if (o_out_valid && !i_out_stall) begin
                if (want_q.size() == 0) begin
                    flag_mismatch("result word with nothing pending", o_mapping_word, '0);
                end else begin
                    exp_r = want_q.pop_front();
                    if (o_bit_value !== exp_r.bitv)
                        flag_mismatch("bit_value", WORD_W'(o_bit_value), WORD_W'(exp_r.bitv));
                    if (o_last !== exp_r.lastv)
                        flag_mismatch("last", WORD_W'(o_last), WORD_W'(exp_r.lastv));
                    if (o_mapping_word !== exp_r.word)
                        flag_mismatch("mapping_word", o_mapping_word, exp_r.word);
                    if (o_gray_flag !== exp_r.gray)
                        flag_mismatch("gray_flag", WORD_W'(o_gray_flag), WORD_W'(exp_r.gray));
                    if (o_perm_number !== exp_r.perm)
                        flag_mismatch("perm_number", WORD_W'(o_perm_number),
                                      WORD_W'(exp_r.perm));
                    if (o_exhausted !== exp_r.exh)
                        flag_mismatch("exhausted", WORD_W'(o_exhausted), WORD_W'(exp_r.exh));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cyc_cnt++;
        if (cyc_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cyc_cnt, want_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic void push_req(logic [REQ_W-1:0] req, logic [CHAR_W-1:0] ch);
        req_fifo.push_back('{req, ch});
    endfunction

    function automatic logic [CHAR_W-1:0] rand_char();
        if ($urandom_range(0, 1)) return CHAR_ZERO + CHAR_W'($urandom_range(0, 15));
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    function automatic void queue_noise(int cnt);
        int r;
        for (int k = 0; k < cnt; k++) begin
            r = $urandom_range(0, 19);
            if (r < 2) push_req(REQ_RESTART, rand_char());
            else if (r < 9) push_req(REQ_ADVANCE, rand_char());
            else if (r < 19) push_req(REQ_MAP, rand_char());
            else push_req(REQ_NONE, rand_char());
        end
    endfunction

    // restart followed by a run of advances with maps sprinkled in
    function automatic void queue_walk(int n_adv);
        push_req(REQ_RESTART, rand_char());
        for (int k = 0; k < n_adv; k++) begin
            push_req(REQ_ADVANCE, rand_char());
            if ($urandom_range(0, 3) == 0) push_req(REQ_MAP, rand_char());
        end
    endfunction

    task automatic drain();
        while (req_fifo.size() != 0 || i_in_valid || want_q.size() != 0) @(posedge i_clk);
        // a trailing request of type 3 gives no word and is dropped at the front end, so settle
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_bps(logic [BPS_W-1:0] v);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data = v;
        do @(negedge i_clk); while (!cfg_taken);
        i_cfg_valid = 1'b0;
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm = ($urandom_range(0, 3) == 0);
    endtask

    initial begin
        bps_reg = BPS_RESET;
        load_identity();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset setting, four entries
        push_req(REQ_RESTART, 8'h00);
        push_req(REQ_MAP, "0");
        push_req(REQ_MAP, "1");
        push_req(REQ_MAP, "2");
        push_req(REQ_MAP, "3");
        push_req(REQ_MAP, 8'h00);
        push_req(REQ_MAP, 8'hFF);
        push_req(REQ_ADVANCE, 8'h00);
        push_req(REQ_MAP, "2");
        push_req(REQ_NONE, 8'hAA);
        drain();

        // two entries: one advance reaches the last mapping, the next one exhausts
        write_bps(3'd1);
        push_req(REQ_RESTART, 8'hFF);
        push_req(REQ_MAP, "0");
        push_req(REQ_MAP, "1");
        push_req(REQ_MAP, "/");
        push_req(REQ_ADVANCE, 8'h55);
        push_req(REQ_MAP, "0");
        push_req(REQ_ADVANCE, 8'h00);
        push_req(REQ_ADVANCE, 8'h00);
        push_req(REQ_MAP, "1");
        push_req(REQ_NONE, 8'h55);
        push_req(REQ_RESTART, 8'h00);
        push_req(REQ_MAP, "0");
        drain();

        write_bps(3'd0);
        queue_noise(12);
        drain();

        // 24 permutations here, the first walk runs past the end
        write_bps(3'd2);
        queue_walk(30);
        queue_noise(5);
        queue_walk(10);
        drain();

        // long receiver hold while words keep coming
        write_bps(3'd7);
        rx_hold_req = 1'b1;
        queue_noise(30);
        drain();

        write_bps(3'd4);
        queue_walk(10);
        queue_noise(10);
        drain();

        write_bps(3'd3);
        queue_walk(12);
        queue_noise(10);
        drain();

        write_bps(3'd5);
        queue_noise(10);
        drain();

        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
